// ----- hw/rtl/blit_engine_2d_defines.svh -----
// ----------------------------------------------------------------------------
// blit_engine_2d_defines: assertion macros
// Shorthand for clocked implication checks, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef BLIT_ENGINE_2D_DEFINES_SVH
`define BLIT_ENGINE_2D_DEFINES_SVH

// same-cycle implication
`define BLIT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BLIT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/blit_pkg.sv -----
// ----------------------------------------------------------------------------
// blit_pkg
// Shared types, opcodes and constants of the 2D blitter.
// ----------------------------------------------------------------------------
`default_nettype none

package blit_pkg;

    localparam int DEF_ADDR_BITS  = 21;
    localparam int DEF_ROW_STRIDE = 2048;

    localparam int OP_BITS   = 3;
    localparam int AFLD_BITS = 21;
    localparam int W_BITS    = 12;
    localparam int H_BITS    = 11;
    localparam int PIX_BITS  = 32;

    localparam logic [OP_BITS-1:0] OP_CLEAR = 3'd0;
    localparam logic [OP_BITS-1:0] OP_FILL  = 3'd1;
    localparam logic [OP_BITS-1:0] OP_COPY  = 3'd2;
    localparam logic [OP_BITS-1:0] OP_KCOPY = 3'd3;
    localparam logic [OP_BITS-1:0] OP_WRITE = 3'd4;
    localparam logic [OP_BITS-1:0] OP_READ  = 3'd5;

    localparam logic [W_BITS-1:0]   CLEAR_W    = 12'd1280;
    localparam logic [H_BITS-1:0]   CLEAR_H    = 11'd1024;
    localparam logic [PIX_BITS-1:0] ALPHA_MASK = 32'hff00_0000;

    typedef struct packed {
        logic [OP_BITS-1:0]   op;
        logic [AFLD_BITS-1:0] dst_addr;
        logic [AFLD_BITS-1:0] src_addr;
        logic [W_BITS-1:0]    width;
        logic [H_BITS-1:0]    height;
        logic [PIX_BITS-1:0]  value;
    } blit_req_t;

    typedef struct packed {
        logic [PIX_BITS-1:0] read_data;
        logic                done_res;
    } blit_rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic load;     // latch the request
        logic advance;  // step to the next pixel
        logic rd_src;   // read source pixel (copy)
        logic rd_dst;   // read destination word (read op)
        logic wr_fill;  // write fill color at destination pointer
        logic wr_word;  // write single word
    } blit_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [OP_BITS-1:0] op;
        logic               empty;
        logic               last;
    } blit_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/blit_ctrl.sv -----
// ----------------------------------------------------------------------------
// blit_ctrl
// Sequencer: decodes the request and steps the datapath pixel by pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module blit_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    output logic                     done,
    output blit_pkg::blit_cmd_t      cmd,
    input  wire blit_pkg::blit_sts_t sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FILL,
        S_COPY,
        S_DRAIN,
        S_WORD,
        S_READ
    } state_t;

    state_t state_reg;
    logic   done_reg;

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    always_comb
    begin
        cmd         = '0;
        cmd.load    = (state_reg == S_IDLE) && start;
        cmd.advance = (state_reg == S_FILL) || (state_reg == S_COPY);
        cmd.rd_src  = (state_reg == S_COPY);
        cmd.rd_dst  = (state_reg == S_READ);
        cmd.wr_fill = (state_reg == S_FILL);
        cmd.wr_word = (state_reg == S_WORD);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                        state_reg <= S_DECODE;
                end
                S_DECODE:
                begin
                    case (sts.op)
                        blit_pkg::OP_CLEAR, blit_pkg::OP_FILL:
                        begin
                            if (sts.empty)
                            begin
                                state_reg <= S_IDLE;
                                done_reg  <= 1'b1;
                            end
                            else
                                state_reg <= S_FILL;
                        end
                        blit_pkg::OP_COPY, blit_pkg::OP_KCOPY:
                        begin
                            if (sts.empty)
                            begin
                                state_reg <= S_IDLE;
                                done_reg  <= 1'b1;
                            end
                            else
                                state_reg <= S_COPY;
                        end
                        blit_pkg::OP_WRITE: state_reg <= S_WORD;
                        blit_pkg::OP_READ:  state_reg <= S_READ;
                        default:
                        begin
                            state_reg <= S_IDLE;
                            done_reg  <= 1'b1;
                        end
                    endcase
                end
                S_FILL:
                begin
                    if (sts.last)
                    begin
                        state_reg <= S_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                S_COPY:
                begin
                    if (sts.last)
                        state_reg <= S_DRAIN;
                end
                S_DRAIN, S_WORD, S_READ:
                begin
                    state_reg <= S_IDLE;
                    done_reg  <= 1'b1;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/blit_dpath.sv -----
// ----------------------------------------------------------------------------
// blit_dpath
// Address walkers, pixel counters and the frame store with read bypass.
// ----------------------------------------------------------------------------
`default_nettype none

module blit_dpath #(
    parameter int ADDR_BITS  = blit_pkg::DEF_ADDR_BITS,
    parameter int ROW_STRIDE = blit_pkg::DEF_ROW_STRIDE
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire blit_pkg::blit_req_t req,
    input  wire blit_pkg::blit_cmd_t cmd,
    output blit_pkg::blit_sts_t      sts,
    output blit_pkg::blit_rsp_t      rsp
);

    localparam logic [ADDR_BITS-1:0] STRIDE_A = ADDR_BITS'(ROW_STRIDE);

    logic [blit_pkg::PIX_BITS-1:0] mem [2**ADDR_BITS];

    logic [blit_pkg::OP_BITS-1:0]  op_reg;
    logic [blit_pkg::PIX_BITS-1:0] value_reg;
    logic [blit_pkg::W_BITS-1:0]   w_reg, col_reg;
    logic [blit_pkg::H_BITS-1:0]   h_reg, row_reg;
    logic [ADDR_BITS-1:0]          dst_row_reg, dst_ptr_reg;
    logic [ADDR_BITS-1:0]          src_row_reg, src_ptr_reg;
    logic [ADDR_BITS-1:0]          pend_dst_reg;
    logic                          cp_vld_reg;
    logic [blit_pkg::PIX_BITS-1:0] rdata_reg;

    logic                          col_last, row_last;
    logic [ADDR_BITS-1:0]          dst_row_next, src_row_next;
    logic                          keyed, key_ok;
    logic                          wen, ren, byp;
    logic [ADDR_BITS-1:0]          waddr, raddr;
    logic [blit_pkg::PIX_BITS-1:0] wdata;

    assign col_last = (col_reg == w_reg - blit_pkg::W_BITS'(1));
    assign row_last = (row_reg == h_reg - blit_pkg::H_BITS'(1));

    assign dst_row_next = dst_row_reg + STRIDE_A;
    assign src_row_next = src_row_reg + STRIDE_A;

    assign sts.op    = op_reg;
    assign sts.empty = (w_reg == '0) || (h_reg == '0);
    assign sts.last  = col_last && row_last;

    // pointer and counter walk
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= req.op;
            value_reg <= req.value;
            col_reg   <= '0;
            row_reg   <= '0;
            if (req.op == blit_pkg::OP_CLEAR)
            begin
                w_reg       <= blit_pkg::CLEAR_W;
                h_reg       <= blit_pkg::CLEAR_H;
                dst_row_reg <= '0;
                dst_ptr_reg <= '0;
            end
            else
            begin
                w_reg       <= req.width;
                h_reg       <= req.height;
                dst_row_reg <= ADDR_BITS'(req.dst_addr);
                dst_ptr_reg <= ADDR_BITS'(req.dst_addr);
            end
            src_row_reg <= ADDR_BITS'(req.src_addr);
            src_ptr_reg <= ADDR_BITS'(req.src_addr);
        end
        else if (cmd.advance)
        begin
            if (col_last)
            begin
                col_reg     <= '0;
                row_reg     <= row_reg + blit_pkg::H_BITS'(1);
                dst_row_reg <= dst_row_next;
                dst_ptr_reg <= dst_row_next;
                src_row_reg <= src_row_next;
                src_ptr_reg <= src_row_next;
            end
            else
            begin
                col_reg     <= col_reg + blit_pkg::W_BITS'(1);
                dst_ptr_reg <= dst_ptr_reg + ADDR_BITS'(1);
                src_ptr_reg <= src_ptr_reg + ADDR_BITS'(1);
            end
        end
    end

    // copy write stage: writes in the cycle after the source read
    always_ff @(posedge clk)
    begin
        if (cmd.rd_src)
            pend_dst_reg <= dst_ptr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cp_vld_reg <= 1'b0;
        else
            cp_vld_reg <= cmd.rd_src;
    end

    assign keyed  = (op_reg == blit_pkg::OP_KCOPY);
    assign key_ok = !keyed || ((rdata_reg & blit_pkg::ALPHA_MASK) != '0);

    always_comb
    begin
        wen   = 1'b0;
        waddr = dst_ptr_reg;
        wdata = value_reg;
        if (cmd.wr_fill || cmd.wr_word)
            wen = 1'b1;
        else if (cp_vld_reg)
        begin
            wen   = key_ok;
            waddr = pend_dst_reg;
            wdata = rdata_reg;
        end
    end

    assign ren   = cmd.rd_src || cmd.rd_dst;
    assign raddr = cmd.rd_src ? src_ptr_reg : dst_ptr_reg;
    // forward the word being written when a read in the same cycle hits it
    assign byp   = wen && (waddr == raddr);

    always_ff @(posedge clk)
    begin
        if (wen)
            mem[waddr] <= wdata;
        if (ren)
            rdata_reg <= byp ? wdata : mem[raddr];
    end

    assign rsp.read_data = (op_reg == blit_pkg::OP_READ) ? rdata_reg : '0;
    assign rsp.done_res  = 1'b1;

endmodule

`default_nettype wire

// ----- hw/rtl/blit_engine_2d.sv -----
// Throughput: one request at a time at one pixel per cycle, bound by the single
//   frame store write port; a new request may be accepted in the strobe cycle.
// Reset clears the sequencer and copy-valid flag; the frame store is undefined until written.
// The receiver cannot stall: each result is valid for the single done cycle.
// ----------------------------------------------------------------------------
// blit_engine_2d
// 2D blitter top level: clear, fill, copy, keyed copy, word write and read.
// ----------------------------------------------------------------------------
`default_nettype none

`include "blit_engine_2d_defines.svh"

module blit_engine_2d #(
    parameter int ADDR_BITS  = blit_pkg::DEF_ADDR_BITS,
    parameter int ROW_STRIDE = blit_pkg::DEF_ROW_STRIDE
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire blit_pkg::blit_req_t req,
    output logic                     done,
    output blit_pkg::blit_rsp_t      rsp
);

    // command and status between sequencer and datapath
    blit_pkg::blit_cmd_t cmd;
    blit_pkg::blit_sts_t sts;

    // Sequencer: decode the request, walk the rectangle, raise done once.
    blit_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .sts   (sts)
    );

    // Datapath: hold request fields, advance pointers with row wrap, and run
    // the frame store. Copies read one pixel per cycle and write it in the
    // following cycle; a read that hits the pending write takes the forwarded
    // word, so overlapping copies match strict row-major order.
    blit_dpath #(
        .ADDR_BITS  (ADDR_BITS),
        .ROW_STRIDE (ROW_STRIDE)
    ) u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (rsp)
    );

    // done is a single-cycle strobe per request
    `BLIT_ASSERT_NEXT(a_done_single, done, !done, "done strobe lasted two cycles")

    // an accepted request holds busy on the following cycle
    `BLIT_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done, "request not held busy")

    // only a read request returns data
    `BLIT_ASSERT_NOW(a_rdata_zero, done && (sts.op != blit_pkg::OP_READ),
        rsp.read_data == '0, "nonzero read_data for non-read request")

endmodule

`default_nettype wire
